@@ hdl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg : shared types, codes and control store for the ASCII formatter
// Holds the format codes, the control word layout, the microprogram and the
// power-of-ten table used by the decimal digit loop.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Format codes carried by in_opcode
  localparam logic [2:0] OP_BIN  = 3'd0;
  localparam logic [2:0] OP_HEXP = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_SDEC = 3'd3;
  localparam logic [2:0] OP_UDEC = 3'd4;

  // ASCII characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_A     = 8'h61;

  // Counter: bit, nibble or power-of-ten index
  localparam int unsigned CNT_W    = 6;
  localparam logic [CNT_W-1:0] POW_LAST = 6'd19;

  // Jump conditions
  localparam logic [3:0] JC_NONE     = 4'd0;
  localparam logic [3:0] JC_ALWAYS   = 4'd1;
  localparam logic [3:0] JC_OP_BIN   = 4'd2;
  localparam logic [3:0] JC_OP_HEXP  = 4'd3;
  localparam logic [3:0] JC_OP_HEX   = 4'd4;
  localparam logic [3:0] JC_OP_SDEC  = 4'd5;
  localparam logic [3:0] JC_OP_UDEC  = 4'd6;
  localparam logic [3:0] JC_ZERO     = 4'd7;
  localparam logic [3:0] JC_POS      = 4'd8;
  localparam logic [3:0] JC_CNT_NZ   = 4'd9;
  localparam logic [3:0] JC_POW_MORE = 4'd10;
  localparam logic [3:0] JC_GE       = 4'd11;

  // Character emit selects
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_ZERO  = 3'd1;
  localparam logic [2:0] EM_X     = 3'd2;
  localparam logic [2:0] EM_MINUS = 3'd3;
  localparam logic [2:0] EM_BIT   = 3'd4;
  localparam logic [2:0] EM_HEX   = 3'd5;
  localparam logic [2:0] EM_DEC   = 3'd6;
  localparam logic [2:0] EM_ZLAST = 3'd7;

  // Counter operations
  localparam logic [2:0] CNT_HOLD = 3'd0;
  localparam logic [2:0] CNT_BITS = 3'd1;
  localparam logic [2:0] CNT_NIBS = 3'd2;
  localparam logic [2:0] CNT_POW  = 3'd3;
  localparam logic [2:0] CNT_DEC  = 3'd4;
  localparam logic [2:0] CNT_INC  = 3'd5;

  // Operand register operations
  localparam logic [1:0] NUM_HOLD = 2'd0;
  localparam logic [1:0] NUM_NEG  = 2'd1;
  localparam logic [1:0] NUM_SUB  = 2'd2;

  // Microprogram entry points
  localparam logic [4:0] A_BIN  = 5'd6;
  localparam logic [4:0] A_BINL = 5'd7;
  localparam logic [4:0] A_HEXP = 5'd9;
  localparam logic [4:0] A_HEX  = 5'd11;
  localparam logic [4:0] A_HEXL = 5'd12;
  localparam logic [4:0] A_ZERO = 5'd14;
  localparam logic [4:0] A_SDEC = 5'd16;
  localparam logic [4:0] A_DEC  = 5'd18;
  localparam logic [4:0] A_SUBL = 5'd19;

  typedef struct packed {
    logic       done;
    logic [3:0] jc;
    logic [4:0] target;
    logic [2:0] emit;
    logic [2:0] cnt_op;
    logic [1:0] num_op;
    logic       dig_clr;
    logic       st_clr;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic pos;
    logic cnt_nz;
    logic pow_more;
    logic ge;
  } stat_t;

  localparam ctrl_t CW_NOP = '{done: 1'b0, jc: JC_NONE, target: 5'd0, emit: EM_NONE,
                               cnt_op: CNT_HOLD, num_op: NUM_HOLD, dig_clr: 1'b0,
                               st_clr: 1'b0};

  function automatic ctrl_t cw_make(input logic done, input logic [3:0] jc,
                                    input logic [4:0] target, input logic [2:0] emit,
                                    input logic [2:0] cnt_op, input logic [1:0] num_op,
                                    input logic dig_clr, input logic st_clr);
    ctrl_t w;
    w.done    = done;
    w.jc      = jc;
    w.target  = target;
    w.emit    = emit;
    w.cnt_op  = cnt_op;
    w.num_op  = num_op;
    w.dig_clr = dig_clr;
    w.st_clr  = st_clr;
    return w;
  endfunction

  // Control store
  function automatic ctrl_t rom_word(input logic [4:0] addr);
    ctrl_t w;
    w = CW_NOP;
    case (addr)
      // dispatch on format code
      5'd0:  w = cw_make(1'b0, JC_OP_BIN,  A_BIN,  EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd1:  w = cw_make(1'b0, JC_OP_HEXP, A_HEXP, EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd2:  w = cw_make(1'b0, JC_OP_HEX,  A_HEX,  EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd3:  w = cw_make(1'b0, JC_OP_SDEC, A_SDEC, EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd4:  w = cw_make(1'b0, JC_OP_UDEC, A_DEC,  EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd5:  w = cw_make(1'b1, JC_NONE,    5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      // binary
      5'd6:  w = cw_make(1'b0, JC_NONE,    5'd0,   EM_NONE, CNT_BITS, NUM_HOLD, 1'b0, 1'b0);
      5'd7:  w = cw_make(1'b0, JC_CNT_NZ,  A_BINL, EM_BIT,  CNT_DEC,  NUM_HOLD, 1'b0, 1'b0);
      5'd8:  w = cw_make(1'b1, JC_NONE,    5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      // hex, with prefix
      5'd9:  w = cw_make(1'b0, JC_NONE,    5'd0,   EM_ZERO, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd10: w = cw_make(1'b0, JC_NONE,    5'd0,   EM_X,    CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd11: w = cw_make(1'b0, JC_ZERO,    A_ZERO, EM_NONE, CNT_NIBS, NUM_HOLD, 1'b0, 1'b1);
      5'd12: w = cw_make(1'b0, JC_CNT_NZ,  A_HEXL, EM_HEX,  CNT_DEC,  NUM_HOLD, 1'b0, 1'b0);
      5'd13: w = cw_make(1'b1, JC_NONE,    5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      // lone zero
      5'd14: w = cw_make(1'b0, JC_NONE,    5'd0,   EM_ZLAST, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd15: w = cw_make(1'b1, JC_NONE,    5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      // signed decimal prologue
      5'd16: w = cw_make(1'b0, JC_POS,     A_DEC,  EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      5'd17: w = cw_make(1'b0, JC_NONE,    5'd0,   EM_MINUS, CNT_HOLD, NUM_NEG, 1'b0, 1'b0);
      // decimal
      5'd18: w = cw_make(1'b0, JC_ZERO,    A_ZERO, EM_NONE, CNT_POW,  NUM_HOLD, 1'b1, 1'b1);
      5'd19: w = cw_make(1'b0, JC_GE,      A_SUBL, EM_NONE, CNT_HOLD, NUM_SUB,  1'b0, 1'b0);
      5'd20: w = cw_make(1'b0, JC_POW_MORE, A_SUBL, EM_DEC, CNT_INC,  NUM_HOLD, 1'b1, 1'b0);
      5'd21: w = cw_make(1'b1, JC_NONE,    5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
      default: w = cw_make(1'b1, JC_NONE,  5'd0,   EM_NONE, CNT_HOLD, NUM_HOLD, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

  // Powers of ten, largest first
  function automatic logic [63:0] pow10(input logic [4:0] idx);
    logic [63:0] p;
    p = 64'd1;
    case (idx)
      5'd0:  p = 64'h8AC7_2304_89E8_0000;
      5'd1:  p = 64'h0DE0_B6B3_A764_0000;
      5'd2:  p = 64'h0163_4578_5D8A_0000;
      5'd3:  p = 64'h0023_86F2_6FC1_0000;
      5'd4:  p = 64'h0003_8D7E_A4C6_8000;
      5'd5:  p = 64'h0000_5AF3_107A_4000;
      5'd6:  p = 64'h0000_0918_4E72_A000;
      5'd7:  p = 64'h0000_00E8_D4A5_1000;
      5'd8:  p = 64'h0000_0017_4876_E800;
      5'd9:  p = 64'h0000_0002_540B_E400;
      5'd10: p = 64'd1000000000;
      5'd11: p = 64'd100000000;
      5'd12: p = 64'd10000000;
      5'd13: p = 64'd1000000;
      5'd14: p = 64'd100000;
      5'd15: p = 64'd10000;
      5'd16: p = 64'd1000;
      5'd17: p = 64'd100;
      5'd18: p = 64'd10;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/itoa_seq.sv @@
// ----------------------------------------------------------------------------
// itoa_seq : microprogram sequencer
// Step counter over the control store, conditional jumps on datapath status
// and the format code, busy flag for the command handshake.
// ----------------------------------------------------------------------------
module itoa_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [2:0]        opcode,
  input  itoa_pkg::stat_t   stat,
  output itoa_pkg::ctrl_t   cw,
  output logic              busy
);

  logic            busy_r, busy_nxt;
  logic [4:0]      upc_r, upc_nxt;
  logic [2:0]      op_r;
  itoa_pkg::ctrl_t word;
  logic            take;

  assign word = itoa_pkg::rom_word(upc_r);
  assign cw   = busy_r ? word : itoa_pkg::CW_NOP;
  assign busy = busy_r;

  always_comb begin
    unique case (word.jc)
      itoa_pkg::JC_NONE:     take = 1'b0;
      itoa_pkg::JC_ALWAYS:   take = 1'b1;
      itoa_pkg::JC_OP_BIN:   take = (op_r == itoa_pkg::OP_BIN);
      itoa_pkg::JC_OP_HEXP:  take = (op_r == itoa_pkg::OP_HEXP);
      itoa_pkg::JC_OP_HEX:   take = (op_r == itoa_pkg::OP_HEX);
      itoa_pkg::JC_OP_SDEC:  take = (op_r == itoa_pkg::OP_SDEC);
      itoa_pkg::JC_OP_UDEC:  take = (op_r == itoa_pkg::OP_UDEC);
      itoa_pkg::JC_ZERO:     take = stat.zero;
      itoa_pkg::JC_POS:      take = stat.pos;
      itoa_pkg::JC_CNT_NZ:   take = stat.cnt_nz;
      itoa_pkg::JC_POW_MORE: take = stat.pow_more;
      itoa_pkg::JC_GE:       take = stat.ge;
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (load) begin
      busy_nxt = 1'b1;
      upc_nxt  = 5'd0;
    end else if (busy_r) begin
      if (take) begin
        upc_nxt = word.target;
      end else if (word.done) begin
        busy_nxt = 1'b0;
        upc_nxt  = 5'd0;
      end else begin
        upc_nxt = upc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= opcode;
    end
  end

endmodule

@@ hdl/itoa_dp.sv @@
// ----------------------------------------------------------------------------
// itoa_dp : formatter datapath
// Operand register with negate and power-of-ten subtract, index counter,
// digit accumulator and the registered character output.
// ----------------------------------------------------------------------------
module itoa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [63:0]       value,
  input  logic              wide,
  input  itoa_pkg::ctrl_t   cw,
  output itoa_pkg::stat_t   stat,
  output logic              out_valid,
  output logic [7:0]        out_character,
  output logic              out_last
);

  logic [63:0]                num_r, num_nxt;
  logic                       wide_r;
  logic [itoa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]                 digit_r, digit_nxt;
  logic                       started_r, started_nxt;
  logic                       valid_r;
  logic [7:0]                 char_r;
  logic                       last_r;

  logic [63:0] pow;
  logic [63:0] diff;
  logic [63:0] neg;
  logic        ge;
  logic        sign;
  logic [3:0]  nib;
  logic [63:0] nib_sh;
  logic [7:0]  hex_ch;
  logic        fire;
  logic [7:0]  ch;
  logic        lst;
  logic        st_set;

  assign pow    = itoa_pkg::pow10(cnt_r[4:0]);
  assign ge     = (num_r >= pow);
  assign diff   = num_r - pow;
  assign neg    = (~num_r + 64'd1) & {{32{wide_r}}, 32'hFFFF_FFFF};
  assign sign   = wide_r ? num_r[63] : num_r[31];
  assign nib_sh = num_r >> {cnt_r[3:0], 2'b00};
  assign nib    = nib_sh[3:0];
  assign hex_ch = (nib > 4'd9) ? (itoa_pkg::CH_A + {4'h0, nib} - 8'd10)
                               : (itoa_pkg::CH_0 + {4'h0, nib});

  assign stat.zero     = (num_r == 64'd0);
  assign stat.pos      = !sign;
  assign stat.cnt_nz   = (cnt_r != '0);
  assign stat.pow_more = (cnt_r != itoa_pkg::POW_LAST);
  assign stat.ge       = ge;

  // character select
  always_comb begin
    fire   = 1'b0;
    ch     = itoa_pkg::CH_0;
    lst    = 1'b0;
    st_set = 1'b0;
    unique case (cw.emit)
      itoa_pkg::EM_NONE: ;
      itoa_pkg::EM_ZERO: fire = 1'b1;
      itoa_pkg::EM_X: begin
        fire = 1'b1;
        ch   = itoa_pkg::CH_X;
      end
      itoa_pkg::EM_MINUS: begin
        fire = 1'b1;
        ch   = itoa_pkg::CH_MINUS;
      end
      itoa_pkg::EM_BIT: begin
        fire = 1'b1;
        ch   = num_r[cnt_r] ? itoa_pkg::CH_1 : itoa_pkg::CH_0;
        lst  = (cnt_r == '0);
      end
      itoa_pkg::EM_HEX: begin
        fire   = started_r || (nib != 4'd0);
        ch     = hex_ch;
        lst    = (cnt_r == '0);
        st_set = 1'b1;
      end
      itoa_pkg::EM_DEC: begin
        fire   = started_r || (digit_r != 4'd0);
        ch     = itoa_pkg::CH_0 + {4'h0, digit_r};
        lst    = (cnt_r == itoa_pkg::POW_LAST);
        st_set = 1'b1;
      end
      itoa_pkg::EM_ZLAST: begin
        fire = 1'b1;
        lst  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cw.cnt_op)
      itoa_pkg::CNT_HOLD: cnt_nxt = cnt_r;
      itoa_pkg::CNT_BITS: cnt_nxt = wide_r ? 6'd63 : 6'd31;
      itoa_pkg::CNT_NIBS: cnt_nxt = wide_r ? 6'd15 : 6'd7;
      itoa_pkg::CNT_POW:  cnt_nxt = wide_r ? 6'd0 : 6'd10;
      itoa_pkg::CNT_DEC:  cnt_nxt = cnt_r - 6'd1;
      itoa_pkg::CNT_INC:  cnt_nxt = cnt_r + 6'd1;
      default:            cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    num_nxt   = num_r;
    digit_nxt = digit_r;
    if (load) begin
      num_nxt = value & {{32{wide}}, 32'hFFFF_FFFF};
    end else if (cw.num_op == itoa_pkg::NUM_NEG) begin
      num_nxt = neg;
    end else if ((cw.num_op == itoa_pkg::NUM_SUB) && ge) begin
      num_nxt   = diff;
      digit_nxt = digit_r + 4'd1;
    end
    if (cw.dig_clr) begin
      digit_nxt = 4'd0;
    end
  end

  always_comb begin
    started_nxt = started_r;
    if (cw.st_clr) begin
      started_nxt = 1'b0;
    end else if (st_set && fire) begin
      started_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      started_r <= 1'b0;
    end else begin
      valid_r   <= fire;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    cnt_r   <= cnt_nxt;
    digit_r <= digit_nxt;
    char_r  <= ch;
    last_r  <= lst;
    if (load) begin
      wide_r <= wide;
    end
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

@@ hdl/integer_to_ascii_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit : integer to ASCII text formatter
// Formats one 32 or 64 bit integer as binary, hex (with or without 0x) or
// signed/unsigned decimal text, one character per output transaction.
// ----------------------------------------------------------------------------
// Using the block: raise start with in_value, in_wide and in_opcode while busy
// is low; the transaction is taken on that edge and busy rises until the last
// character has been produced. Characters leave one per out_valid pulse, each
// present for a single cycle, and out_last marks the final one of the
// transaction. There is no back-pressure: the receiver must take every
// character the cycle it appears. Timing is set by the microprogram: dispatch
// tests the format code against binary, hex with prefix, hex, signed and
// unsigned decimal in turn, then binary emits one bit per cycle, hex steps one
// nibble per cycle, and decimal subtracts one power of ten per cycle until it
// no longer fits, then emits the digit. In hex and decimal a zero operand
// prints a single 0 (after any 0x prefix); unknown format codes produce no
// characters and drop busy once dispatch has found no match.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  input  logic        in_wide,
  input  logic [2:0]  in_opcode,
  output logic        out_valid,
  output logic [7:0]  out_character,
  output logic        out_last
);

  logic            load;
  itoa_pkg::ctrl_t cw;
  itoa_pkg::stat_t stat;

  // accept a new transaction only when the sequencer is idle
  assign load = start && !busy;

  // sequencer: steps through the control store, jumps on status
  itoa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .opcode (in_opcode),
    .stat   (stat),
    .cw     (cw),
    .busy   (busy)
  );

  // datapath: hold the operand, advance the index, emit characters
  itoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .value         (in_value),
    .wide          (in_wide),
    .cw            (cw),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

@@ test/formatter_text_checker.sv @@
// ----------------------------------------------------------------------------
// formatter_text_checker : scoreboard for the integer to ASCII formatter
// Watches the command and character channels. Each accepted command is turned
// into the text it should print, and every character that leaves the block is
// compared with the oldest character still owed.
// ----------------------------------------------------------------------------
module formatter_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_value,
  input  logic        in_wide,
  input  logic [2:0]  in_opcode,
  input  logic        out_valid,
  input  logic [7:0]  out_character,
  input  logic        out_last,
  output int          chars_pending,
  output int          mismatch_count
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  text_char_t owed_text[$];

  // Work out the text of one command and queue it, last character marked.
  function automatic void predict_text(input logic [63:0] value, input logic wide,
                                       input logic [2:0] opcode);
    logic [7:0]  chars[$];
    logic [7:0]  digits[$];
    logic [63:0] operand;
    logic [63:0] mask;
    logic [3:0]  nib;
    logic        seen;
    int          width;
    text_char_t  entry;
    mask    = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
    operand = value & mask;
    width   = wide ? 64 : 32;
    case (opcode)
      itoa_pkg::OP_BIN: begin
        for (int b = width - 1; b >= 0; b--) begin
          chars.push_back(operand[b] ? itoa_pkg::CH_1 : itoa_pkg::CH_0);
        end
      end
      itoa_pkg::OP_HEXP, itoa_pkg::OP_HEX: begin
        if (opcode == itoa_pkg::OP_HEXP) begin
          chars.push_back(itoa_pkg::CH_0);
          chars.push_back(itoa_pkg::CH_X);
        end
        if (operand == 64'd0) begin
          chars.push_back(itoa_pkg::CH_0);
        end else begin
          seen = 1'b0;
          for (int n = width / 4 - 1; n >= 0; n--) begin
            nib = operand[4*n +: 4];
            if (nib != 4'd0) seen = 1'b1;
            if (seen) begin
              chars.push_back(nib > 4'd9 ? itoa_pkg::CH_A + 8'(nib) - 8'd10
                                         : itoa_pkg::CH_0 + 8'(nib));
            end
          end
        end
      end
      itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC: begin
        // most negative value negates onto itself and prints as its magnitude
        if (opcode == itoa_pkg::OP_SDEC && operand[width-1]) begin
          chars.push_back(itoa_pkg::CH_MINUS);
          operand = (~operand + 64'd1) & mask;
        end
        if (operand == 64'd0) begin
          chars.push_back(itoa_pkg::CH_0);
        end else begin
          while (operand != 64'd0) begin
            digits.push_front(itoa_pkg::CH_0 + 8'(operand % 64'd10));
            operand = operand / 64'd10;
          end
          foreach (digits[i]) chars.push_back(digits[i]);
        end
      end
      default: ; // unknown format codes print nothing
    endcase
    foreach (chars[i]) begin
      entry.character = chars[i];
      entry.last      = (i == chars.size() - 1);
      owed_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin : watch
    text_char_t want;
    logic       bad;
    if (!rst_n) begin
      owed_text.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid) begin
        if (owed_text.size() == 0) begin
          $display("%0t: unexpected character 0x%02h last %0b, nothing owed", $time,
                   out_character, out_last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = owed_text.pop_front();
          bad  = 1'b0;
          if (out_character !== want.character) begin
            $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h", $time,
                     want.character, out_character);
            bad = 1'b1;
          end
          if (out_last !== want.last) begin
            $display("%0t: last flag mismatch: expected %0b, actual %0b", $time,
                     want.last, out_last);
            bad = 1'b1;
          end
          if (bad) mismatch_count <= mismatch_count + 1;
        end
      end
      if (start && !busy) predict_text(in_value, in_wide, in_opcode);
    end
    chars_pending <= owed_text.size();
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench : top level for the integer to ASCII formatter
// Drives format commands in random bursts, first a directed set of corner
// values then random ones, and lets the text checker score every character.
// ----------------------------------------------------------------------------
module testbench;

  // Format codes the block does not know; these must print nothing
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  localparam int RANDOM_NUMBERS = 96;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic [63:0] in_value  = 64'd0;
  logic        in_wide   = 1'b0;
  logic [2:0]  in_opcode = itoa_pkg::OP_BIN;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_character;
  logic        out_last;
  int          chars_pending;
  int          mismatch_count;

  // Transactions left in the current burst; zero means a gap comes next
  int burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  integer_to_ascii_formatter_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_wide       (in_wide),
    .in_opcode     (in_opcode),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  formatter_text_checker i_text_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_wide        (in_wide),
    .in_opcode      (in_opcode),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last),
    .chars_pending  (chars_pending),
    .mismatch_count (mismatch_count)
  );

  // Send one format command. At the start of a burst, drop start for a gap
  // of random length first, with junk on the payload so nothing leaks
  // through while start is low. Hold start high until the block takes it.
  task automatic send_number(input logic [63:0] value, input logic wide,
                             input logic [2:0] opcode);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 90); // long enough to land mid-number
      endcase
      if (gap > 0) begin
        start     <= 1'b0;
        in_value  <= {$urandom, $urandom};
        in_wide   <= 1'($urandom_range(0, 1));
        in_opcode <= 3'($urandom_range(itoa_pkg::OP_BIN, OP_UNUSED_HI));
        repeat (gap) @(posedge clk);
      end
    end
    start     <= 1'b1;
    in_value  <= value;
    in_wide   <= wide;
    in_opcode <= opcode;
    // busy read here is its value before this edge, so a low one means taken
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  // Drop start and hold off until the block is idle and every character owed
  // has come out. Sample on the falling edge to stay clear of the checker.
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (chars_pending != 0 || busy);
    @(posedge clk);
    burst_left = 0;
  endtask

  // Random operand, weighted towards the values that stress formatting:
  // digit boundaries, sign boundaries, lone nibbles and the all-ones pattern.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4: v = 64'($urandom_range(0, 1000));
      5: begin
        v = 64'd1;
        repeat ($urandom_range(0, 19)) v = v * 64'd10;
        v = v - 64'd1 + 64'($urandom_range(0, 2));
      end
      6: v = -64'($urandom_range(1, 1000));
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 64'h8000_0000_0000_0000;
          1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
          2:       v = {$urandom, 32'h8000_0000};
          default: v = {$urandom, 32'h7FFF_FFFF};
        endcase
      end
      8: v = 64'($urandom_range(1, 15)) << (4 * $urandom_range(0, 15));
      default: v = $urandom_range(0, 1) ? '1 : 64'd0;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int          sent;
    logic [63:0] value;
    logic [2:0]  opcode;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: every format at both widths, zero, all ones, the
    // most negative value, the largest power of ten and junk above bit 31.
    send_number(64'd0,                   1'b0, itoa_pkg::OP_BIN);
    send_number('1,                      1'b1, itoa_pkg::OP_BIN);
    send_number(64'hA5A5_A5A5_5A5A_5A5A, 1'b0, itoa_pkg::OP_BIN);
    send_number(64'd0,                   1'b0, itoa_pkg::OP_HEXP);
    send_number('1,                      1'b1, itoa_pkg::OP_HEXP);
    send_number(64'hFFFF_FFFF_0000_0010, 1'b0, itoa_pkg::OP_HEX);
    send_number(64'd1,                   1'b1, itoa_pkg::OP_HEX);
    send_number(64'd0,                   1'b1, itoa_pkg::OP_HEX);
    send_number(64'h0000_0000_8000_0000, 1'b0, itoa_pkg::OP_SDEC);
    send_number(64'h8000_0000_0000_0000, 1'b1, itoa_pkg::OP_SDEC);
    send_number(64'h1234_5678_FFFF_FFFF, 1'b0, itoa_pkg::OP_SDEC);
    send_number('1,                      1'b1, itoa_pkg::OP_SDEC);
    send_number(64'h0000_0000_7FFF_FFFF, 1'b0, itoa_pkg::OP_SDEC);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, itoa_pkg::OP_SDEC);
    send_number(64'd0,                   1'b0, itoa_pkg::OP_SDEC);
    send_number('1,                      1'b1, itoa_pkg::OP_UDEC);
    send_number('1,                      1'b0, itoa_pkg::OP_UDEC);
    send_number(64'd0,                   1'b1, itoa_pkg::OP_UDEC);
    send_number(64'd10000000000000000000, 1'b1, itoa_pkg::OP_UDEC);
    send_number(64'd9,                   1'b0, itoa_pkg::OP_UDEC);
    send_number(64'h0000_0000_3B9A_CA00, 1'b0, itoa_pkg::OP_UDEC);
    send_number('1,                      1'b1, OP_UNUSED_LO);
    send_number(64'd0,                   1'b0, OP_UNUSED_MID);
    send_number(64'd5,                   1'b1, OP_UNUSED_HI);

    // Random part; unknown codes are sprinkled in but not counted
    sent = 0;
    while (sent < RANDOM_NUMBERS) begin
      value = pick_value();
      if ($urandom_range(0, 19) == 0) begin
        opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
        opcode = 3'($urandom_range(itoa_pkg::OP_BIN, itoa_pkg::OP_UDEC));
      end
      send_number(value, 1'($urandom_range(0, 1)), opcode);
      if (opcode <= itoa_pkg::OP_UDEC) sent++;
      // pause now and then until the block has caught up completely
      if (sent == RANDOM_NUMBERS / 2 || $urandom_range(0, 39) == 0) wait_until_drained();
    end

    wait_until_drained();
    // give any stray character a chance to show before the verdict
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** integer_to_ascii_formatter_unit: PASSED **");
    end else begin
      $display("** integer_to_ascii_formatter_unit: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("** integer_to_ascii_formatter_unit: FAILED **");
    $finish;
  end

endmodule
